// ----- rtl/ffa_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
package ffa_pkg;
  localparam int MaxBlocks   = 64;
  localparam int HeaderBytes = 32;
  localparam int MaxRequest  = 100000000;
  localparam int IdxW        = $clog2(MaxBlocks);
  localparam int CntW        = $clog2(MaxBlocks + 1);
  localparam int SizeW       = 27;
  localparam int MetaW       = 13;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_ZALLOC = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_RESIZE = 2'd3
  } cmd_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    cmd_t              cmd;
    logic              size_ok;
    logic [SizeW-1:0]  size;
    logic              present;
    logic [31:0]       ptr;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_FIT,
    ST_DECIDE,
    ST_APPEND,
    ST_DONE
  } state_t;
endpackage

// ----- rtl/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator.
// The result strobe comes after the front stages and any table walks; a walk reads one table
// entry per cycle up to the block count, and a growing resize walks the table twice.
// Throughput: one item at a time; busy stays high through the result strobe and drops
// the cycle after it.
// Reset clears the block count, break and tallies and loads heap_limit to 16 MiB.
module first_fit_block_allocator import ffa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_command,
  input  logic [31:0]      in_request_size,
  input  logic [31:0]      in_item_count,
  input  logic             in_pointer_present,
  input  logic [31:0]      in_pointer_offset,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_heap_limit,
  output logic             out_valid,
  output logic             out_success,
  output logic [31:0]      out_result_offset,
  output logic             out_copy_needed,
  output logic [31:0]      out_copy_source,
  output logic [SizeW-1:0] out_copy_length,
  output logic             out_zero_needed,
  output logic [CntW-1:0]  out_free_block_count,
  output logic [31:0]      out_free_byte_count,
  output logic [CntW-1:0]  out_total_block_count,
  output logic [31:0]      out_total_byte_count,
  output logic [MetaW-1:0] out_metadata_byte_count
);
  logic [31:0] heap_limit_r;
  logic        q_valid, q_pop, back_busy;
  req_t        q_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) heap_limit_r <= 32'd16777216;
    else if (cfg_valid) heap_limit_r <= cfg_heap_limit;
  end

  ffa_front u_front (
    .clk, .rst_n, .start, .busy, .in_command, .in_request_size, .in_item_count,
    .in_pointer_present, .in_pointer_offset, .q_valid, .q_data, .q_pop, .back_busy
  );

  ffa_back u_back (
    .clk, .rst_n, .heap_limit(heap_limit_r), .q_valid, .q_data, .q_pop, .back_busy,
    .out_valid, .out_success, .out_result_offset, .out_copy_needed, .out_copy_source,
    .out_copy_length, .out_zero_needed, .out_free_block_count, .out_free_byte_count,
    .out_total_block_count, .out_total_byte_count, .out_metadata_byte_count
  );
endmodule

// ----- rtl/ffa_front.sv -----
// Front part: accepts items, checks and forms the size, and queues them.
module ffa_front import ffa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_item_count,
  input  logic        in_pointer_present,
  input  logic [31:0] in_pointer_offset,
  output logic        q_valid,
  output req_t        q_data,
  input  logic        q_pop,
  input  logic        back_busy
);
  // Stage one registers the product, stage two checks it and queues the item.
  logic        s1_valid_r;
  cmd_t        s1_cmd_r;
  logic [63:0] s1_prod_r;
  logic        s1_present_r;
  logic [31:0] s1_ptr_r;
  logic        q_valid_r;
  req_t        q_data_r;
  logic [63:0] prod;

  assign prod = (cmd_t'(in_command) == CMD_ZALLOC) ?
                64'(in_item_count) * 64'(in_request_size) : 64'(in_request_size);
  assign busy = s1_valid_r | q_valid_r | back_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      q_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= start & ~busy;
      if (s1_valid_r) q_valid_r <= 1'b1;
      else if (q_pop) q_valid_r <= 1'b0;
    end
    if (start && !busy) begin
      s1_cmd_r     <= cmd_t'(in_command);
      s1_prod_r    <= prod;
      s1_present_r <= in_pointer_present;
      s1_ptr_r     <= in_pointer_offset;
    end
    if (s1_valid_r) begin
      q_data_r.cmd     <= s1_cmd_r;
      q_data_r.size_ok <= (s1_prod_r != 64'd0) && (s1_prod_r <= 64'(MaxRequest));
      q_data_r.size    <= s1_prod_r[SizeW-1:0];
      q_data_r.present <= s1_present_r;
      q_data_r.ptr     <= s1_ptr_r;
    end
  end

  assign q_valid = q_valid_r;
  assign q_data  = q_data_r;
endmodule

// ----- rtl/ffa_back.sv -----
// Back part: walks the block table to find and fit, then updates the tallies.
module ffa_back import ffa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      heap_limit,
  input  logic             q_valid,
  input  req_t             q_data,
  output logic             q_pop,
  output logic             back_busy,
  output logic             out_valid,
  output logic             out_success,
  output logic [31:0]      out_result_offset,
  output logic             out_copy_needed,
  output logic [31:0]      out_copy_source,
  output logic [SizeW-1:0] out_copy_length,
  output logic             out_zero_needed,
  output logic [CntW-1:0]  out_free_block_count,
  output logic [31:0]      out_free_byte_count,
  output logic [CntW-1:0]  out_total_block_count,
  output logic [31:0]      out_total_byte_count,
  output logic [MetaW-1:0] out_metadata_byte_count
);
  logic [31:0]      start_mem [MaxBlocks];
  logic [SizeW-1:0] size_mem  [MaxBlocks];
  logic             free_mem  [MaxBlocks];

  state_t           state_r, state_nxt;
  req_t             req_r;
  logic [CntW-1:0]  idx_r, idx_nxt;
  logic [CntW-1:0]  bcount_r;
  logic [31:0]      brk_r;
  logic [CntW-1:0]  fblk_r;
  logic [31:0]      fbyte_r, tbyte_r;
  logic             found_r, found_nxt;
  logic [IdxW-1:0]  fidx_r, fidx_nxt;
  logic [SizeW-1:0] fsize_r, fsize_nxt;
  logic             ffree_r, ffree_nxt;
  logic             rd_pend_r;
  logic [31:0]      rd_start_r;
  logic [SizeW-1:0] rd_size_r;
  logic             rd_free_r;
  logic             ok_r, copy_r;
  logic [31:0]      res_r;
  logic [33:0]      end_sum;
  logic             take_now, walk_end;

  assign end_sum  = 34'(brk_r) + 34'(HeaderBytes) + 34'(req_r.size);
  assign walk_end = (idx_r >= bcount_r);

  // Reads are registered, so read data belongs to the previous index; rd_pend_r marks valid read data.
  always_ff @(posedge clk) begin
    rd_start_r <= start_mem[idx_r[IdxW-1:0]];
    rd_size_r  <= size_mem[idx_r[IdxW-1:0]];
    rd_free_r  <= free_mem[idx_r[IdxW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    fidx_nxt  = fidx_r;
    fsize_nxt = fsize_r;
    ffree_nxt = ffree_r;
    q_pop     = 1'b0;
    take_now  = 1'b0;
    case (state_r)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        idx_nxt = '0;
        found_nxt = 1'b0;
        case (q_data.cmd)
          CMD_FREE:   state_nxt = q_data.present ? ST_FIND : ST_DONE;
          CMD_RESIZE: state_nxt = !q_data.size_ok ? ST_DONE :
                                  (q_data.present ? ST_FIND : ST_FIT);
          default:    state_nxt = q_data.size_ok ? ST_FIT : ST_DONE;
        endcase
      end
      ST_FIND: begin
        if (rd_pend_r && rd_start_r + 32'(HeaderBytes) == req_r.ptr) begin
          found_nxt = 1'b1;
          fidx_nxt  = IdxW'(idx_r - 1'b1);
          fsize_nxt = rd_size_r;
          ffree_nxt = rd_free_r;
          state_nxt = ST_DECIDE;
          idx_nxt   = '0;
        end else if (walk_end) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        // Free, shrink or grow for a found block.
        if (req_r.cmd == CMD_FREE || req_r.size <= fsize_r) state_nxt = ST_DONE;
        else state_nxt = ST_FIT;
      end
      ST_FIT: begin
        if (rd_pend_r && rd_free_r && rd_size_r >= req_r.size) begin
          take_now  = 1'b1;
          state_nxt = ST_DONE;
        end else if (walk_end) begin
          state_nxt = ST_APPEND;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_APPEND: state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bcount_r <= '0;
      brk_r    <= '0;
      fblk_r   <= '0;
      fbyte_r  <= '0;
      tbyte_r  <= '0;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == ST_DONE);
      // Read data holds entry idx_r - 1 only while the same walk keeps going.
      rd_pend_r <= (state_r == ST_FIND || state_r == ST_FIT) && (state_nxt == state_r) &&
                   (idx_r < bcount_r);
      if (state_r == ST_IDLE && q_valid) begin
        req_r  <= q_data;
        ok_r   <= (q_data.cmd == CMD_FREE) && !q_data.present;
        copy_r <= 1'b0;
        res_r  <= '0;
      end
      if (state_r == ST_DECIDE) begin
        if (req_r.cmd == CMD_FREE) begin
          ok_r <= 1'b1;
          if (!ffree_r) begin
            free_mem[fidx_r] <= 1'b1;
            fblk_r  <= fblk_r + 1'b1;
            fbyte_r <= fbyte_r + 32'(fsize_r);
          end
        end else if (req_r.size <= fsize_r) begin
          ok_r  <= 1'b1;
          res_r <= req_r.ptr;
          if (ffree_r) begin
            free_mem[fidx_r] <= 1'b0;
            fblk_r  <= fblk_r - 1'b1;
            fbyte_r <= fbyte_r - 32'(fsize_r);
          end
        end
      end
      if (take_now) begin
        free_mem[IdxW'(idx_r - 1'b1)] <= 1'b0;
        ok_r   <= 1'b1;
        res_r  <= rd_start_r + 32'(HeaderBytes);
        copy_r <= found_r;
        if (found_r && !ffree_r) begin
          free_mem[fidx_r] <= 1'b1;
          fblk_r  <= fblk_r;
          fbyte_r <= fbyte_r - 32'(rd_size_r) + 32'(fsize_r);
        end else begin
          fblk_r  <= fblk_r - 1'b1;
          fbyte_r <= fbyte_r - 32'(rd_size_r);
        end
      end
      if (state_r == ST_APPEND && bcount_r < CntW'(MaxBlocks) &&
          end_sum <= 34'(heap_limit)) begin
        start_mem[bcount_r[IdxW-1:0]] <= brk_r;
        size_mem[bcount_r[IdxW-1:0]]  <= req_r.size;
        free_mem[bcount_r[IdxW-1:0]]  <= 1'b0;
        res_r    <= brk_r + 32'(HeaderBytes);
        brk_r    <= end_sum[31:0];
        bcount_r <= bcount_r + 1'b1;
        tbyte_r  <= tbyte_r + 32'(req_r.size);
        ok_r     <= 1'b1;
        copy_r   <= found_r;
        if (found_r && !ffree_r) begin
          free_mem[fidx_r] <= 1'b1;
          fblk_r  <= fblk_r + 1'b1;
          fbyte_r <= fbyte_r + 32'(fsize_r);
        end
      end
    end
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    fidx_r  <= fidx_nxt;
    fsize_r <= fsize_nxt;
    ffree_r <= ffree_nxt;
  end

  assign back_busy               = (state_r != ST_IDLE) || out_valid;
  assign out_success             = ok_r;
  assign out_result_offset       = res_r;
  assign out_copy_needed         = copy_r;
  assign out_copy_source         = copy_r ? req_r.ptr : 32'd0;
  assign out_copy_length         = copy_r ? fsize_r : '0;
  assign out_zero_needed         = ok_r && (req_r.cmd == CMD_ZALLOC);
  assign out_free_block_count    = fblk_r;
  assign out_free_byte_count     = fbyte_r;
  assign out_total_block_count   = bcount_r;
  assign out_total_byte_count    = tbyte_r;
  assign out_metadata_byte_count = MetaW'(32'(bcount_r) * 32'(HeaderBytes));
endmodule

// ----- rtl/ffa_checker.sv -----
// Port-level checks for the first-fit block allocator.
module ffa_checker import ffa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_success,
  input logic             out_copy_needed,
  input logic             out_zero_needed,
  input logic [CntW-1:0]  out_free_block_count,
  input logic [CntW-1:0]  out_total_block_count
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_block_count <= out_total_block_count)
    else $error("more free blocks than blocks");
  a_flags_need_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_copy_needed || out_zero_needed) |-> out_success)
    else $error("copy or zero flag on failed item");
endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for the first-fit block allocator.
module tb;
  import ffa_pkg::*;

  typedef struct {
    logic             success;
    logic [31:0]      result_offset;
    logic             copy_needed;
    logic [31:0]      copy_source;
    logic [SizeW-1:0] copy_length;
    logic             zero_needed;
    logic [CntW-1:0]  free_blocks;
    logic [31:0]      free_bytes;
    logic [CntW-1:0]  total_blocks;
    logic [31:0]      total_bytes;
    logic [MetaW-1:0] meta_bytes;
  } outcome_t;

  class alloc_scoreboard;
    logic [31:0]      heap_limit = 32'd16777216;
    logic [31:0]      blk_start [MaxBlocks];
    logic [SizeW-1:0] blk_size  [MaxBlocks];
    bit               blk_free  [MaxBlocks];
    int               blk_count = 0;
    logic [31:0]      brk = 0;
    int               free_blocks = 0;
    logic [31:0]      free_bytes = 0;
    logic [31:0]      total_bytes = 0;
    outcome_t         pending [$];
    int               errors = 0;

    task report(string msg);
      errors++;
      if (errors <= 40) $display("tb: mismatch: %s", msg);
    endtask

    function bit size_bad(logic [63:0] sz);
      return sz == 0 || sz > MaxRequest;
    endfunction

    function void mark_used(int i);
      if (blk_free[i]) begin
        blk_free[i] = 0;
        free_blocks--;
        free_bytes -= blk_size[i];
      end
    endfunction

    function void mark_free(int i);
      if (!blk_free[i]) begin
        blk_free[i] = 1;
        free_blocks++;
        free_bytes += blk_size[i];
      end
    endfunction

    function bit take(logic [31:0] sz, output logic [31:0] off);
      logic [63:0] top;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_size[i] >= sz) begin
          mark_used(i);
          off = blk_start[i] + HeaderBytes;
          return 1;
        end
      end
      off = 0;
      if (blk_count >= MaxBlocks) return 0;
      top = 64'(brk) + HeaderBytes + 64'(sz);
      if (top > 64'(heap_limit)) return 0;
      blk_start[blk_count] = brk;
      blk_size[blk_count] = sz[SizeW-1:0];
      blk_free[blk_count] = 0;
      off = brk + HeaderBytes;
      brk = top[31:0];
      blk_count++;
      total_bytes += sz;
      return 1;
    endfunction

    function int lookup(logic [31:0] ptr);
      for (int i = 0; i < blk_count; i++)
        if (64'(blk_start[i]) + HeaderBytes == 64'(ptr)) return i;
      return MaxBlocks;
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_item(cmd_t cmd, logic [31:0] req, logic [31:0] cnt, logic pres,
                            logic [31:0] ptr);
      outcome_t o;
      logic [31:0] off;
      logic [63:0] prod;
      int idx;
      o = '{default: 0};
      case (cmd)
        CMD_ALLOC: begin
          if (!size_bad(req) && take(req, off)) begin
            o.success = 1;
            o.result_offset = off;
          end
        end
        CMD_ZALLOC: begin
          prod = 64'(cnt) * 64'(req);
          if (cnt != 0 && !size_bad(prod) && take(prod[31:0], off)) begin
            o.success = 1;
            o.result_offset = off;
            o.zero_needed = 1;
          end
        end
        CMD_FREE: begin
          if (!pres) o.success = 1;
          else begin
            idx = lookup(ptr);
            if (idx < MaxBlocks) begin
              mark_free(idx);
              o.success = 1;
            end
          end
        end
        default: begin
          if (!size_bad(req)) begin
            if (!pres) begin
              if (take(req, off)) begin
                o.success = 1;
                o.result_offset = off;
              end
            end else begin
              idx = lookup(ptr);
              if (idx < MaxBlocks) begin
                if (req <= blk_size[idx]) begin
                  mark_used(idx);
                  o.success = 1;
                  o.result_offset = ptr;
                end else if (take(req, off)) begin
                  o.success = 1;
                  o.result_offset = off;
                  o.copy_needed = 1;
                  o.copy_source = ptr;
                  o.copy_length = blk_size[idx];
                  mark_free(idx);
                end
              end
            end
          end
        end
      endcase
      o.free_blocks = free_blocks[CntW-1:0];
      o.free_bytes = free_bytes;
      o.total_blocks = blk_count[CntW-1:0];
      o.total_bytes = total_bytes;
      o.meta_bytes = MetaW'(blk_count * HeaderBytes);
      pending.push_back(o);
    endfunction

    task field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(outcome_t g);
      outcome_t e;
      if (pending.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      e = pending.pop_front();
      field("success", g.success, e.success);
      field("result_offset", g.result_offset, e.result_offset);
      field("copy_needed", g.copy_needed, e.copy_needed);
      field("copy_source", g.copy_source, e.copy_source);
      field("copy_length", g.copy_length, e.copy_length);
      field("zero_needed", g.zero_needed, e.zero_needed);
      field("free_block_count", g.free_blocks, e.free_blocks);
      field("free_byte_count", g.free_bytes, e.free_bytes);
      field("total_block_count", g.total_blocks, e.total_blocks);
      field("total_byte_count", g.total_bytes, e.total_bytes);
      field("metadata_byte_count", g.meta_bytes, e.meta_bytes);
    endtask
  endclass

  logic clk = 0;
  logic rst_n;
  logic start, busy;
  logic [1:0] in_command;
  logic [31:0] in_request_size, in_item_count, in_pointer_offset;
  logic in_pointer_present;
  logic cfg_valid, cfg_ready;
  logic [31:0] cfg_heap_limit;
  logic out_valid, out_success, out_copy_needed, out_zero_needed;
  logic [31:0] out_result_offset, out_copy_source, out_free_byte_count, out_total_byte_count;
  logic [SizeW-1:0] out_copy_length;
  logic [CntW-1:0] out_free_block_count, out_total_block_count;
  logic [MetaW-1:0] out_metadata_byte_count;

  alloc_scoreboard sb = new();
  int idle_pct = 0;
  int cycles = 0;

  always #2 clk = ~clk;

  first_fit_block_allocator dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result('{out_success, out_result_offset, out_copy_needed, out_copy_source,
                          out_copy_length, out_zero_needed, out_free_block_count,
                          out_free_byte_count, out_total_block_count,
                          out_total_byte_count, out_metadata_byte_count});
      if (start && !busy)
        sb.note_item(cmd_t'(in_command), in_request_size, in_item_count,
                     in_pointer_present, in_pointer_offset);
      if (cfg_valid && cfg_ready) sb.heap_limit = cfg_heap_limit;
    end
  end

  task send(cmd_t cmd, logic [31:0] req, logic [31:0] cnt, logic pres, logic [31:0] ptr);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    in_command <= cmd;
    in_request_size <= req;
    in_item_count <= cnt;
    in_pointer_present <= pres;
    in_pointer_offset <= ptr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits for every outstanding result, then for the block to go fully quiet.
  task drain;
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task write_limit(logic [31:0] v);
    cfg_valid <= 1;
    cfg_heap_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function logic [31:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 300);
    if (r < 80) return $urandom_range(1, MaxRequest);
    if (r < 90) return $urandom;
    if (r < 94) return 0;
    if (r < 97) return MaxRequest;
    return MaxRequest + 1;
  endfunction

  task random_item;
    cmd_t cmd;
    logic [31:0] req, cnt, ptr;
    logic pres;
    int r;
    cmd = cmd_t'($urandom_range(3));
    req = pick_size();
    cnt = $urandom;
    ptr = $urandom;
    pres = 1;
    r = $urandom_range(99);
    if (r < 10) pres = 0;
    else if (r < 85 && sb.blk_count > 0)
      ptr = sb.blk_start[$urandom_range(sb.blk_count - 1)] + HeaderBytes;
    if (cmd == CMD_ZALLOC && $urandom_range(99) < 75) begin
      cnt = $urandom_range(1, 8);
      req = $urandom_range(1, 40);
    end
    send(cmd, req, cnt, pres, ptr);
  endtask

  initial begin
    logic [31:0] limits [5];
    int pcts [4];
    pcts = '{0, 67, 0, 34};
    rst_n = 0;
    start <= 0;
    in_command <= CMD_ALLOC;
    in_request_size <= 0;
    in_item_count <= 0;
    in_pointer_present <= 0;
    in_pointer_offset <= 0;
    cfg_valid <= 0;
    cfg_heap_limit <= 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed checks at the reset heap limit.
    send(CMD_ALLOC, 0, 0, 0, 0);
    send(CMD_ALLOC, MaxRequest + 1, 0, 0, 0);
    send(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    send(CMD_ALLOC, MaxRequest, 0, 0, 0);
    send(CMD_ALLOC, 1, 0, 0, 0);
    send(CMD_ALLOC, 100, 0, 0, 0);
    send(CMD_ZALLOC, 5, 0, 0, 0);
    send(CMD_ZALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send(CMD_ZALLOC, 10, 10, 0, 0);
    send(CMD_FREE, 0, 0, 0, 32'hFFFF_FFFF);
    send(CMD_FREE, 0, 0, 1, 5);
    send(CMD_FREE, 0, 0, 1, 65);
    send(CMD_FREE, 0, 0, 1, 65);
    send(CMD_ALLOC, 1, 0, 0, 0);
    send(CMD_RESIZE, 50, 0, 0, 0);
    send(CMD_RESIZE, 80, 0, 1, 197);
    send(CMD_RESIZE, 500, 0, 1, 197);
    send(CMD_RESIZE, 500, 0, 1, 12345);
    send(CMD_RESIZE, 0, 0, 1, 32);
    send(CMD_FREE, 0, 0, 1, 32);
    send(CMD_RESIZE, 1, 0, 1, 32);
    drain();

    limits = '{32'd0, 32'hFFFF_FFFF, sb.brk + $urandom_range(0, 5000), 32'd16777216, 32'd5000};
    foreach (limits[p]) begin
      if (p == 2) limits[p] = sb.brk + $urandom_range(0, 5000);
      write_limit(limits[p]);
      for (int i = 0; i < 280; i++) begin
        if (i % 70 == 0) idle_pct = pcts[(i / 70) % 4];
        random_item();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/ffa_pkg.sv
rtl/ffa_front.sv
rtl/ffa_back.sv
rtl/first_fit_block_allocator.sv
rtl/ffa_checker.sv
dv/tb.sv
